### sv/bpq_pkg.sv
package bpq_pkg;

  localparam int BUTTON_COUNT = 4;
  localparam int TIMER_BITS   = 16;
  localparam int CFG_BITS     = (TIMER_BITS > BUTTON_COUNT) ? TIMER_BITS : BUTTON_COUNT;

  typedef logic [TIMER_BITS-1:0] timer_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CONFIRM_TICKS    = 2'd0,
    REG_GUARD_SPAN       = 2'd1,
    REG_LONG_PRESS_TICKS = 2'd2,
    REG_LONG_ENABLE_MASK = 2'd3
  } reg_index_t;

  localparam timer_t                  CONFIRM_TICKS_RST    = timer_t'(50);
  localparam timer_t                  GUARD_SPAN_RST       = timer_t'(200);
  localparam timer_t                  LONG_PRESS_TICKS_RST = timer_t'(1000);
  localparam logic [BUTTON_COUNT-1:0] LONG_ENABLE_MASK_RST = BUTTON_COUNT'(13);

  // settings shared by every button machine
  typedef struct packed {
    timer_t confirm_ticks;
    timer_t guard_span;
    timer_t long_press_ticks;
  } timing_cfg_t;

  // per-button result of one tick
  typedef struct packed {
    logic press;
    logic long_press;
    logic armed;
  } button_status_t;

  // button phase, one-hot
  typedef enum logic [4:0] {
    PH_ARMED   = 5'b00001,
    PH_CONFIRM = 5'b00010,
    PH_HELD    = 5'b00100,
    PH_REJECT  = 5'b01000,
    PH_REARM   = 5'b10000
  } phase_t;

  // saturating increment
  function automatic timer_t sat_inc(input timer_t v);
    timer_t r;
    if (v == {TIMER_BITS{1'b1}}) begin
      r = v;
    end else begin
      r = v + timer_t'(1);
    end
    return r;
  endfunction

endpackage

### sv/bpq_channels.sv
interface tick_if import bpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BUTTON_COUNT-1:0] button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink (input valid, input button_levels, output ready);
endinterface

interface result_if import bpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [BUTTON_COUNT-1:0] press_events;
  logic [BUTTON_COUNT-1:0] long_flags;
  logic [BUTTON_COUNT-1:0] armed_buttons;

  modport source (output valid, output press_events, output long_flags,
                  output armed_buttons, input ready);
  modport sink (input valid, input press_events, input long_flags,
                input armed_buttons, output ready);
endinterface

### sv/button_press_qualifier_top.sv
// Debounces and qualifies four active-low buttons. Each input item is one
// tick of sampled pin levels; each accepted item yields exactly one result
// item with per-button press, long-press and armed bits. Every button runs
// its own phase machine with saturating 16-bit timers, all updated in the
// cycle an item is accepted, so one item is taken per clock and its result
// appears in the output register on the next cycle. The input is ready
// whenever the output register is empty or being emptied. Registers
// (confirm, guard, long-press ticks and long-enable mask) are written via
// cfg port, by the user only while no result is outstanding, unchecked.
module button_press_qualifier_top import bpq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  tick_if.sink                in_ch,
  result_if.source            out_ch
);

  timing_cfg_t             timing;
  logic [BUTTON_COUNT-1:0] long_enable_mask;
  logic                    tick;
  logic                    out_valid;
  button_status_t          status [BUTTON_COUNT];
  logic [BUTTON_COUNT-1:0] press_next, long_next, armed_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timing.confirm_ticks    <= CONFIRM_TICKS_RST;
      timing.guard_span       <= GUARD_SPAN_RST;
      timing.long_press_ticks <= LONG_PRESS_TICKS_RST;
      long_enable_mask        <= LONG_ENABLE_MASK_RST;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_CONFIRM_TICKS:    timing.confirm_ticks    <= cfg_data[TIMER_BITS-1:0];
        REG_GUARD_SPAN:       timing.guard_span       <= cfg_data[TIMER_BITS-1:0];
        REG_LONG_PRESS_TICKS: timing.long_press_ticks <= cfg_data[TIMER_BITS-1:0];
        REG_LONG_ENABLE_MASK: long_enable_mask        <= cfg_data[BUTTON_COUNT-1:0];
        default: ;
      endcase
    end
  end

  // handshake: take an item when the result register is free or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign tick        = in_ch.valid && in_ch.ready;

  // one machine per button
  for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_button
    bpq_button u_button (
      .clk         (clk),
      .rst         (rst),
      .tick        (tick),
      .level       (in_ch.button_levels[b]),
      .long_enable (long_enable_mask[b]),
      .timing      (timing),
      .status      (status[b])
    );
    assign press_next[b] = status[b].press;
    assign long_next[b]  = status[b].long_press;
    assign armed_next[b] = status[b].armed;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_ch.press_events  <= press_next;
      out_ch.long_flags    <= long_next;
      out_ch.armed_buttons <= armed_next;
    end
  end

  assign out_ch.valid = out_valid;

  // a long flag only ever comes with its press event
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_ch.long_flags & ~out_ch.press_events) == '0))
    else $error("long flag without press event");

  // a released button goes to re-arm, so it cannot be armed on that tick
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_ch.press_events & out_ch.armed_buttons) == '0))
    else $error("button armed on its press event");

  // long flags only on buttons enabled for long presses
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_ch.long_flags & ~long_enable_mask) == '0))
    else $error("long flag on disabled button");

  // nothing is offered straight after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

### sv/bpq_button.sv
module bpq_button import bpq_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           tick,
  input  logic           level,
  input  logic           long_enable,
  input  timing_cfg_t    timing,
  output button_status_t status
);

  phase_t phase, phase_next;
  timer_t confirm_timer, confirm_timer_next;
  timer_t held_count, held_count_next;
  timer_t since_release, since_release_next;
  logic   released_once, released_once_next;
  logic   previous_level;

  timer_t ct_inc;
  timer_t sr_inc;
  logic   guard_pass;

  always_comb begin
    ct_inc     = sat_inc(confirm_timer);
    sr_inc     = sat_inc(since_release);
    guard_pass = (timing.guard_span == '0) || !released_once ||
                 (sr_inc >= timing.guard_span);

    phase_next          = phase;
    confirm_timer_next  = confirm_timer;
    held_count_next     = held_count;
    since_release_next  = sr_inc;
    released_once_next  = released_once;
    status.press        = 1'b0;
    status.long_press   = 1'b0;

    case (phase)
      PH_CONFIRM: begin
        confirm_timer_next = ct_inc;
        if (ct_inc >= timing.confirm_ticks) begin
          if (!level && guard_pass) begin
            phase_next      = PH_HELD;
            held_count_next = '0;
          end else if (!level) begin
            phase_next = PH_REJECT;
          end else begin
            phase_next         = PH_REARM;
            confirm_timer_next = '0;
          end
        end
      end
      PH_HELD: begin
        if (!level) begin
          held_count_next = sat_inc(held_count);
        end else begin
          status.press       = 1'b1;
          status.long_press  = long_enable && (held_count >= timing.long_press_ticks);
          since_release_next = '0;
          released_once_next = 1'b1;
          phase_next         = PH_REARM;
          confirm_timer_next = '0;
        end
      end
      PH_REJECT: begin
        if (level) begin
          phase_next         = PH_REARM;
          confirm_timer_next = '0;
        end
      end
      PH_REARM: begin
        confirm_timer_next = ct_inc;
        if (ct_inc >= timing.confirm_ticks) begin
          phase_next = PH_ARMED;
        end
      end
      default: begin
        // armed, and any broken code falls back to armed behaviour
        phase_next = PH_ARMED;
        if (previous_level && !level) begin
          phase_next         = PH_CONFIRM;
          confirm_timer_next = '0;
        end
      end
    endcase

    status.armed = (phase_next == PH_ARMED);
  end

  // state advances once per accepted tick item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ARMED;
      confirm_timer  <= '0;
      held_count     <= '0;
      since_release  <= '0;
      released_once  <= 1'b0;
      previous_level <= 1'b1;
    end else if (tick) begin
      phase          <= phase_next;
      confirm_timer  <= confirm_timer_next;
      held_count     <= held_count_next;
      since_release  <= since_release_next;
      released_once  <= released_once_next;
      previous_level <= level;
    end
  end

endmodule
